// ===== rtl/thrp_pkg.sv =====
// ----------------------------------------------------------------------------
// thrp_pkg
// Shared types and constants of the TRNG health test and report packer.
// ----------------------------------------------------------------------------
package thrp_pkg;

	// report and health test limits
	localparam int MAX_REPORT_BYTES = 64;
	localparam int RUN_LIMIT        = 4;
	localparam int LEN_W            = 7;
	localparam int RUN_W            = 3;
	localparam int CMD_DEPTH        = 2;
	localparam int CMD_PTR_W        = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W        = $clog2(CMD_DEPTH + 1);

	localparam logic [7:0]       REPORT_ID     = 8'h01;
	localparam logic [LEN_W-1:0] LEN_MIN       = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(MAX_REPORT_BYTES);
	localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(64);
	localparam logic [31:0]      WORD_ZEROS    = 32'h0000_0000;
	localparam logic [31:0]      WORD_ONES     = 32'hFFFF_FFFF;

	// fault codes
	typedef enum logic [2:0] {
		FAULT_NONE   = 3'd0,
		FAULT_SEED   = 3'd1,
		FAULT_CLOCK  = 3'd2,
		FAULT_STUCK  = 3'd3,
		FAULT_EQUAL  = 3'd4,
		FAULT_REPEAT = 3'd5,
		FAULT_RUN    = 3'd6
	} fault_t;

	// health test phase
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_RUN    = 2'd2
	} phase_t;

	// input word
	typedef struct packed {
		logic [31:0] random_word;
		logic        seed_error;
		logic        clock_error;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       report_end;
		logic       run_last;
		logic [2:0] fault_code;
	} out_word_t;

	// command from the checker to the byte sequencer
	typedef struct packed {
		logic [31:0] word;
		logic        emit_id;
		logic [2:0]  copy;
		logic        rep_end;
		fault_t      fault;
	} cmd_t;

	// checker status
	typedef struct packed {
		phase_t phase;
		fault_t fault;
	} front_status_t;

endpackage

// ===== rtl/thrp_front.sv =====
// ----------------------------------------------------------------------------
// thrp_front
// Health checker: startup test, flag, repeat and top-byte run checks, and
// report position tracking. Emits one command per word that has results.
// ----------------------------------------------------------------------------
module thrp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  thrp_pkg::in_word_t          in_item,
	input  logic [thrp_pkg::LEN_W-1:0]  report_length,
	output logic                        cmd_push,
	output thrp_pkg::cmd_t              cmd,
	output thrp_pkg::front_status_t     status
);
	import thrp_pkg::*;

	logic [31:0]      prev_q, prev_d;
	logic [RUN_W-1:0] run_q, run_d, run_inc;
	logic [LEN_W-1:0] pos_q, pos_d;
	phase_t           phase_q, phase_d;
	fault_t           fault_q, fcode;

	logic             produce;
	logic             startup_ok;
	logic             top_eq;
	logic [LEN_W-1:0] len, pos0, pos1, room, pos2;
	logic [2:0]       copy;
	logic             emit_id, rep_end;

	// effective report length and position arithmetic
	always_comb begin
		if (report_length < LEN_MIN) len = LEN_MIN;
		else if (report_length > LEN_MAX) len = LEN_MAX;
		else len = report_length;
		pos0    = (pos_q >= len) ? '0 : pos_q;
		emit_id = (pos0 == '0);
		pos1    = emit_id ? LEN_W'(1) : pos0;
		room    = len - pos1;
		copy    = (room < LEN_W'(4)) ? room[2:0] : 3'd4;
		pos2    = pos1 + LEN_W'(copy);
		rep_end = (pos2 >= len);
	end

	// checks in priority order
	always_comb begin
		fcode      = FAULT_NONE;
		produce    = 1'b0;
		startup_ok = 1'b0;
		prev_d     = prev_q;
		run_d      = run_q;
		pos_d      = pos_q;
		top_eq     = (in_item.random_word[31:24] == prev_q[31:24]);
		run_inc    = run_q + RUN_W'(1);
		if (fault_q != FAULT_NONE) begin
			fcode = fault_q;
		end else if (phase_q != PH_RUN) begin
			if (in_item.random_word == WORD_ZEROS || in_item.random_word == WORD_ONES) begin
				fcode = FAULT_STUCK;
			end else if (phase_q == PH_SECOND && in_item.random_word == prev_q) begin
				fcode = FAULT_EQUAL;
			end else begin
				startup_ok = 1'b1;
				prev_d     = in_item.random_word;
			end
		end else if (in_item.seed_error) begin
			fcode = FAULT_SEED;
		end else if (in_item.clock_error) begin
			fcode = FAULT_CLOCK;
		end else if (in_item.random_word == prev_q) begin
			fcode = FAULT_REPEAT;
		end else if (top_eq && run_inc >= RUN_W'(RUN_LIMIT)) begin
			fcode = FAULT_RUN;
			run_d = run_inc;
		end else begin
			run_d   = top_eq ? run_inc : '0;
			prev_d  = in_item.random_word;
			pos_d   = rep_end ? '0 : pos2;
			produce = 1'b1;
		end
		if (fcode != FAULT_NONE) produce = 1'b1;
	end

	// phase next state
	always_comb begin
		phase_d = phase_q;
		if (accept && startup_ok) begin
			case (phase_q)
				PH_FIRST:  phase_d = PH_SECOND;
				PH_SECOND: phase_d = PH_RUN;
				default:   phase_d = phase_q;
			endcase
		end
	end

	// command outputs
	always_comb begin
		cmd_push      = accept && produce;
		cmd.word      = in_item.random_word;
		cmd.emit_id   = emit_id;
		cmd.copy      = copy;
		cmd.rep_end   = rep_end;
		cmd.fault     = fcode;
		status.phase  = phase_q;
		status.fault  = fault_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			fault_q <= FAULT_NONE;
			prev_q  <= '0;
			run_q   <= '0;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				fault_q <= fcode;
				prev_q  <= prev_d;
				run_q   <= run_d;
				pos_q   <= pos_d;
			end
		end
	end

endmodule

// ===== rtl/thrp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// thrp_cmd_fifo
// Short command queue between the checker and the byte sequencer.
// ----------------------------------------------------------------------------
module thrp_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  thrp_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            rd_en,
	output thrp_pkg::cmd_t  rd_cmd,
	output logic            empty
);
	import thrp_pkg::*;

	cmd_t                 slot_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_wr, do_rd;

	assign full   = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
				: wr_ptr_q + CMD_PTR_W'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
				: rd_ptr_q + CMD_PTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + CMD_CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CMD_CNT_W'(1);
		end
	end

endmodule

// ===== rtl/thrp_back.sv =====
// ----------------------------------------------------------------------------
// thrp_back
// Byte sequencer: unpacks one command into its report ID, data bytes or
// fault word, one result word per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module thrp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  thrp_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output thrp_pkg::out_word_t out_item
);
	import thrp_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic [2:0] n_res;
	logic [1:0] sel;
	logic       last, is_fault, advance;

	// result count and byte select
	always_comb begin
		is_fault = (cur_q.fault != FAULT_NONE);
		n_res    = is_fault ? 3'd1 : cur_q.copy + 3'(cur_q.emit_id);
		last     = (idx_q == n_res - 3'd1);
		sel      = 2'(idx_q - 3'(cur_q.emit_id));
	end

	// result word
	always_comb begin
		empty = !cur_valid_q;
		if (is_fault) begin
			out_item.out_byte   = '0;
			out_item.report_end = 1'b0;
			out_item.run_last   = 1'b1;
		end else begin
			if (cur_q.emit_id && idx_q == '0) begin
				out_item.out_byte = REPORT_ID;
			end else begin
				case (sel)
					2'd0:    out_item.out_byte = cur_q.word[7:0];
					2'd1:    out_item.out_byte = cur_q.word[15:8];
					2'd2:    out_item.out_byte = cur_q.word[23:16];
					default: out_item.out_byte = cur_q.word[31:24];
				endcase
			end
			out_item.report_end = cur_q.rep_end && last;
			out_item.run_last   = last;
		end
		out_item.fault_code = cur_q.fault;
	end

	// load the next command when idle or on the final byte
	assign advance = !cur_valid_q || (pop && last);
	assign cmd_pop = advance && !cmd_empty;

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			cur_valid_q <= !cmd_empty;
			idx_q       <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

// ===== rtl/trng_health_test_report_packer_unit.sv =====
// ----------------------------------------------------------------------------
// trng_health_test_report_packer_unit
// Entropy health checker and report byte packer, top level.
// ----------------------------------------------------------------------------
// A word is taken whenever the command queue has room; the checker decides
// it at once. The result side gives one byte a cycle while the receiver pops,
// so a running word yields one to five bytes (five when it opens a report,
// fewer when the report ends inside it), a fault word one byte, and a startup
// word that passes none. The byte sequencer sets the sustained rate; the
// two-entry queue lets words arrive while earlier bytes are drained. The user
// must write report_length only while the block is idle; it is not enforced.
module trng_health_test_report_packer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  thrp_pkg::in_word_t          in_item,
	output logic                        empty,
	input  logic                        pop,
	output thrp_pkg::out_word_t         out_item,
	input  logic                        cfg_wr_en,
	input  logic [thrp_pkg::LEN_W-1:0]  cfg_wr_data
);
	import thrp_pkg::*;

	logic             [LEN_W-1:0] len_q;
	logic             accept;
	logic             cmd_push, cmd_pop, cmd_empty;
	cmd_t             cmd_in, cmd_out;
	front_status_t    status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= LEN_RESET;
		else if (cfg_wr_en) len_q <= cfg_wr_data;
	end

	assign accept = push && !full;

	thrp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_item       (in_item),
		.report_length (len_q),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.status        (status)
	);

	thrp_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_cmd (cmd_out),
		.empty  (cmd_empty)
	);

	thrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

	// a latched fault never changes
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status.fault != FAULT_NONE) |=> (status.fault == $past(status.fault)))
		else $error("latched fault changed");

	// a fault word is a single zero byte closing its word
	a_fault_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.fault_code != 3'd0) |->
		(out_item.run_last && !out_item.report_end && out_item.out_byte == 8'h00))
		else $error("malformed fault word");

	// a report ends only on a word's last byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.report_end) |-> out_item.run_last)
		else $error("report end before last byte");

	// startup phases send nothing unless a fault is latched
	a_startup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(status.phase != PH_RUN && status.fault == FAULT_NONE) |-> cmd_empty)
		else $error("startup word queued output");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for trng_health_test_report_packer_unit. Words go in through the
// push/full queue port and report bytes are drained through empty/pop. A
// behavioral model of the health checker and the byte packer, kept in step
// with every accepted word, predicts each byte.
// Coverage: startup words, report length sweeps with clamping and short
// tails, back pressure, and one latched fault with the halted behavior after it.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import thrp_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 150;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block ports, inputs all known from time zero
	logic             push = 1'b0;
	logic             full;
	in_word_t         in_item = '0;
	logic             empty;
	logic             pop = 1'b0;
	out_word_t        out_item;
	logic             cfg_wr_en = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;

	trng_health_test_report_packer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_item     (in_item),
		.empty       (empty),
		.pop         (pop),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// model of the checker and packer state
	logic [LEN_W-1:0] cfg_report_len = LEN_RESET;
	logic [31:0]      last_word = '0;
	logic [RUN_W-1:0] top_byte_streak = '0;
	phase_t           health_phase = PH_FIRST;
	logic [LEN_W-1:0] report_pos = '0;
	fault_t           halt_code = FAULT_NONE;

	out_word_t expected_bytes[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int words_sent = 0;
	int bytes_checked = 0;
	int errors = 0;

	// fault byte; latches the code
	function automatic void expect_fault(fault_t code);
		out_word_t r;
		halt_code = code;
		r = '0;
		r.run_last = 1'b1;
		r.fault_code = code;
		expected_bytes.push_back(r);
	endfunction

	// health check and packing of one accepted word
	function automatic void predict_word(in_word_t w);
		out_word_t r;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] pos;
		logic ends;
		int copy;
		if (halt_code != FAULT_NONE) begin
			expect_fault(halt_code);
			return;
		end
		// startup pair: flags ignored, no bytes unless it fails
		if (health_phase != PH_RUN) begin
			if (w.random_word == WORD_ZEROS || w.random_word == WORD_ONES) begin
				expect_fault(FAULT_STUCK);
				return;
			end
			if (health_phase == PH_SECOND && w.random_word == last_word) begin
				expect_fault(FAULT_EQUAL);
				return;
			end
			last_word = w.random_word;
			if (health_phase == PH_FIRST)
				health_phase = PH_SECOND;
			else
				health_phase = PH_RUN;
			return;
		end
		// running checks, in priority order
		if (w.seed_error) begin
			expect_fault(FAULT_SEED);
			return;
		end
		if (w.clock_error) begin
			expect_fault(FAULT_CLOCK);
			return;
		end
		if (w.random_word == last_word) begin
			expect_fault(FAULT_REPEAT);
			return;
		end
		if (w.random_word[31:24] == last_word[31:24]) begin
			top_byte_streak = top_byte_streak + 1'b1;
			if (top_byte_streak >= RUN_LIMIT) begin
				expect_fault(FAULT_RUN);
				return;
			end
		end else begin
			top_byte_streak = '0;
		end
		last_word = w.random_word;
		// clamp the length; a shrunk length restarts the report
		len = cfg_report_len;
		if (len < LEN_MIN)
			len = LEN_MIN;
		if (len > LEN_MAX)
			len = LEN_MAX;
		pos = report_pos;
		if (pos >= len)
			pos = '0;
		r = '0;
		if (pos == 0) begin
			r.out_byte = REPORT_ID;
			expected_bytes.push_back(r);
			pos = 1;
		end
		copy = (int'(len - pos) < 4) ? int'(len - pos) : 4;
		ends = (int'(pos) + copy >= int'(len));
		// bytes past the report end are dropped
		for (int i = 0; i < copy; i++) begin
			r.out_byte = w.random_word[8*i +: 8];
			r.run_last = (i == copy - 1);
			r.report_end = (i == copy - 1) && ends;
			expected_bytes.push_back(r);
		end
		if (ends)
			report_pos = '0;
		else
			report_pos = pos + LEN_W'(copy);
	endfunction

	// running word that passes: never a repeat, top-byte streak kept below the limit
	function automatic logic [31:0] fresh_word();
		logic [31:0] w;
		w = $urandom();
		if (top_byte_streak < RUN_LIMIT - 1 && $urandom_range(3) == 0)
			w[31:24] = last_word[31:24];
		else if (w[31:24] == last_word[31:24])
			w[31:24] = last_word[31:24] + 8'd1;
		if (w == last_word)
			w[0] = ~w[0];
		return w;
	endfunction

	// offer one word and wait until it is taken
	task automatic send_word(input logic [31:0] word, input logic seed, input logic clock);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item.random_word = word;
		in_item.seed_error = seed;
		in_item.clock_error = clock;
		do @(posedge clk); while (full);
		predict_word(in_item);
		words_sent++;
	endtask

	// stop offering, drain all bytes, then let a silent startup word finish
	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_report_length(input logic [LEN_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_report_len = v;
	endtask

	// receiver: long hold-off counted here, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			pop = ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// compare each popped byte with the oldest prediction
	always @(posedge clk) begin : check_result
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected result word: out_byte %0h fault_code %0d",
					out_item.out_byte, out_item.fault_code);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				check_field("out_byte", want.out_byte, out_item.out_byte);
				check_field("report_end", want.report_end, out_item.report_end);
				check_field("run_last", want.run_last, out_item.run_last);
				check_field("fault_code", want.fault_code, out_item.fault_code);
			end
		end
	end

	// startup pair near the extremes, flags set to show they are ignored
	task automatic test_startup();
		send_word(32'h0000_0001, 1'b1, 1'b1);
		send_word(32'hFFFF_FFFE, 1'b1, 1'b0);
	endtask

	// field extremes, top-byte streak of three, shrink, clamping, short tails
	task automatic test_directed_reports();
		send_word(32'h0000_0000, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(32'h1234_5678, 1'b0, 1'b0);
		send_word(32'h12AA_AAAA, 1'b0, 1'b0);
		send_word(32'h1255_5555, 1'b0, 1'b0);
		send_word(32'h1200_0001, 1'b0, 1'b0);
		send_word(32'h8000_0000, 1'b0, 1'b0);
		// shorter than the current position: next word opens a report
		set_report_length(7'd3);
		send_word(32'h5A5A_A5A5, 1'b0, 1'b0);
		send_word(32'hA5A5_5A5B, 1'b0, 1'b0);
		// below the minimum acts as 2
		set_report_length(7'd0);
		send_word(32'h0102_0304, 1'b0, 1'b0);
		send_word(32'hC3C3_C3C3, 1'b0, 1'b0);
		// above the maximum acts as 64
		set_report_length(7'd127);
		send_word(32'h7E7E_7E7E, 1'b0, 1'b0);
	endtask

	// random words under each idling mix and a sweep of report lengths
	task automatic test_random_traffic();
		logic [LEN_W-1:0] lengths[8];
		int idle_mix[4];
		int stall_mix[4];
		lengths = '{7'd2, 7'd64, 7'd1, 7'd5, 7'd65, 7'd6, 7'd4, 7'd63};
		idle_mix = '{0, 73, 0, 38};
		stall_mix = '{0, 0, 73, 38};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			for (int s = 0; s < 2; s++) begin
				set_report_length(lengths[2*p + s]);
				repeat (9) send_word(fresh_word(), 1'b0, 1'b0);
			end
		end
	endtask

	// receiver holds off so the block fills, then the sender waits for a drain
	task automatic test_backpressure();
		set_report_length(LEN_W'($urandom_range(2, 64)));
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (10) send_word(fresh_word(), 1'b0, 1'b0);
		wait_drained();
		stall_pct = 50;
		repeat (6) send_word(fresh_word(), 1'b0, 1'b0);
	endtask

	// one running fault, then the halted block answers every word with it
	task automatic test_fault_halt();
		logic [31:0] w;
		send_idle_pct = 20;
		stall_pct = 20;
		case ($urandom_range(3))
			0: send_word(fresh_word(), 1'b1, 1'($urandom()));
			1: send_word(last_word, 1'b0, 1'b1);
			2: send_word(last_word, 1'b0, 1'b0);
			default: begin
				while (halt_code == FAULT_NONE) begin
					w = {last_word[31:24], 24'($urandom())};
					if (w == last_word)
						w[0] = ~w[0];
					send_word(w, 1'b0, 1'b0);
				end
			end
		endcase
		repeat (4) send_word($urandom(), 1'($urandom()), 1'($urandom()));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 20;
		stall_pct = 20;
		test_startup();
		test_directed_reports();
		test_random_traffic();
		test_backpressure();
		test_fault_halt();
		wait_drained();
		$display("Sent %0d words and checked %0d report bytes over lengths 0 to 127,",
			words_sent, bytes_checked);
		$display("with back pressure, and halted on fault code %0d.", halt_code);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
